// ----- hdl/lrw_pkg.sv -----
// Lattice random walk: shared package.
// Field widths, register indices and the sequencer state type.
// No dependencies.
package lrw_pkg;

    localparam int DRAW_W     = 4;
    localparam int STEP_W     = 32;
    localparam int AXIS_W     = 3;
    localparam int MEAN_W     = 24;
    localparam int MSQ_W      = 38;
    localparam int MSD_W      = 41;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int FRAC_BITS  = 8;

    localparam logic [CFG_IDX_W-1:0] REG_DIMENSIONS   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WALKER_COUNT = 4'd1;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_UPD   = 6'b000100,
        S_DMEAN = 6'b001000,
        S_DMSQ  = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

endpackage

// ----- hdl/lattice_random_walk_msd.sv -----
// Lattice random walk with per-axis mean and mean square displacement.
// Uses lrw_pkg, lrw_ram (walker positions) and lrw_div (end-of-step statistics).
//
// Each direction_draw beat moves the next walker one lattice step on axis draw/2
// (odd draw +1, even -1, coordinates saturate at +/-(2^(POS_BITS-1)-1)); a draw
// at or above 2*dimensions only uses up that walker's turn. The position memory is
// read when a draw is accepted and written back in S_UPD, where the running
// per-axis sums are updated. After the last walker of a time step one result beat
// per axis follows (mean and mean square in Q.8, msd_total and last on the final
// beat); each axis takes two passes through the bit-serial divider, and no draw
// is taken until the final beat is loaded. After reset and after every register
// write all MAX_WALKERS*MAX_DIMS entries of the position memory are cleared, one
// entry a cycle, during which no draw is accepted.
module lattice_random_walk_msd #(
    parameter int MAX_DIMS    = 4,
    parameter int MAX_WALKERS = 1024,
    parameter int POS_BITS    = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lrw_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [lrw_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [lrw_pkg::DRAW_W-1:0]          i_direction_draw,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [lrw_pkg::STEP_W-1:0]          o_step_number,
    output logic [lrw_pkg::AXIS_W-1:0]          o_axis_index,
    output logic signed [lrw_pkg::MEAN_W-1:0]   o_mean_position,
    output logic [lrw_pkg::MSQ_W-1:0]           o_mean_square,
    output logic [lrw_pkg::MSD_W-1:0]           o_msd_total,
    output logic                                o_last
);

    localparam int DEPTH  = MAX_WALKERS * MAX_DIMS;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int AX_W   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int DIM_W  = $clog2(MAX_DIMS + 1);
    localparam int WK_W   = $clog2(MAX_WALKERS + 1);
    localparam int CS_W   = WK_W + POS_BITS;
    localparam int SQ_W   = WK_W + 2 * (POS_BITS - 1);
    localparam int DV_W   = SQ_W + lrw_pkg::FRAC_BITS;
    localparam int MN_W   = POS_BITS + lrw_pkg::FRAC_BITS + 1;
    localparam int MQ_W   = 2 * POS_BITS + 6;
    localparam int MD_W   = MQ_W + 3;
    localparam int MNX_W  = (MN_W > lrw_pkg::MEAN_W) ? MN_W : lrw_pkg::MEAN_W;
    localparam int MQX_W  = (MQ_W > lrw_pkg::MSQ_W) ? MQ_W : lrw_pkg::MSQ_W;
    localparam int MDX_W  = (MD_W > lrw_pkg::MSD_W) ? MD_W : lrw_pkg::MSD_W;
    localparam int DIMS_RST = (MAX_DIMS < 2) ? MAX_DIMS : 2;

    localparam logic signed [POS_BITS-1:0] POS_MAX = {1'b0, {(POS_BITS-1){1'b1}}};
    localparam logic signed [POS_BITS-1:0] POS_MIN = -POS_MAX;

    lrw_pkg::t_state r_state;

    logic [DIM_W-1:0]              r_dims;
    logic [WK_W-1:0]               r_walkers;
    logic [WK_W-1:0]               r_widx;
    logic [lrw_pkg::STEP_W-1:0]    r_step;
    logic [AW-1:0]                 r_clr_addr;
    logic [AW-1:0]                 r_addr;
    logic [AX_W-1:0]               r_axis;
    logic                          r_up;
    logic                          r_move;
    logic [AX_W-1:0]               r_ax_cnt;
    logic                          r_go;
    logic                          r_neg;
    logic signed [MN_W-1:0]        r_mean;
    logic [MQ_W-1:0]               r_msq;
    logic [MD_W-1:0]               r_msd;
    logic signed [CS_W-1:0]        r_cs [MAX_DIMS];
    logic [SQ_W-1:0]               r_sq [MAX_DIMS];

    logic                          r_out_valid;
    logic [lrw_pkg::STEP_W-1:0]    r_o_step;
    logic [lrw_pkg::AXIS_W-1:0]    r_o_axis;
    logic signed [lrw_pkg::MEAN_W-1:0] r_o_mean;
    logic [lrw_pkg::MSQ_W-1:0]     r_o_msq;
    logic [lrw_pkg::MSD_W-1:0]     r_o_msd;
    logic                          r_o_last;

    logic                          w_cfg_wr;
    logic                          w_in_acc;
    logic                          w_out_free;
    logic [2:0]                    w_draw_axis;
    logic                          w_draw_ok;
    logic [AW-1:0]                 w_base;
    logic [AW-1:0]                 w_draw_addr;
    logic [AX_W-1:0]               w_sum_addr;
    logic signed [CS_W-1:0]        w_cs_sel;
    logic [SQ_W-1:0]               w_sq_sel;
    logic [CS_W-1:0]               w_cs_mag;
    logic                          w_mem_we;
    logic [AW-1:0]                 w_mem_addr;
    logic [POS_BITS-1:0]           w_mem_wdata;
    logic [POS_BITS-1:0]           w_mem_rdata;
    logic signed [POS_BITS-1:0]    w_old;
    logic                          w_can;
    logic signed [POS_BITS-1:0]    w_new;
    logic signed [SQ_W:0]          w_old_x;
    logic signed [SQ_W:0]          w_sq_delta;
    logic signed [CS_W-1:0]        n_cs;
    logic [SQ_W-1:0]               n_sq;
    logic                          w_step_end;
    logic                          w_div_start;
    logic [DV_W-1:0]               w_div_dividend;
    logic                          w_div_done;
    logic [DV_W-1:0]               w_div_quo;
    logic [MQ_W-1:0]               w_quo_msq;
    logic signed [MN_W-1:0]        w_quo_mean;
    logic                          w_ax_last;
    logic [MD_W-1:0]               n_msd;
    logic signed [MNX_W-1:0]       w_mean_x;
    logic [MQX_W-1:0]              w_msq_x;
    logic [MDX_W-1:0]              w_msd_x;
    logic [DIM_W-1:0]              w_cfg_dims;
    logic [WK_W-1:0]               w_cfg_walk;
    logic [3:0]                    w_dims_raw;
    logic [16:0]                   w_walk_raw;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid &&
                         (i_cfg_index == lrw_pkg::REG_DIMENSIONS ||
                          i_cfg_index == lrw_pkg::REG_WALKER_COUNT);
    assign o_in_ready  = (r_state == lrw_pkg::S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // Register values clamped to the supported range on write.
    assign w_dims_raw = i_cfg_data[3:0];
    assign w_walk_raw = 17'(i_cfg_data[10:0]);

    always_comb begin
        if (w_dims_raw == 4'd0) begin
            w_cfg_dims = DIM_W'(1);
        end else if (w_dims_raw > 4'(MAX_DIMS)) begin
            w_cfg_dims = DIM_W'(MAX_DIMS);
        end else begin
            w_cfg_dims = DIM_W'(w_dims_raw);
        end
        if (w_walk_raw == 17'd0) begin
            w_cfg_walk = WK_W'(1);
        end else if (w_walk_raw > 17'(MAX_WALKERS)) begin
            w_cfg_walk = WK_W'(MAX_WALKERS);
        end else begin
            w_cfg_walk = WK_W'(w_walk_raw);
        end
    end

    // Draw decode and position address.
    assign w_draw_axis = i_direction_draw[3:1];
    assign w_draw_ok   = ({1'b0, w_draw_axis} < 4'(r_dims));
    assign w_base      = AW'(32'(r_widx) * 32'(MAX_DIMS));
    assign w_draw_addr = w_base + AW'(w_draw_axis);

    // Per-axis sums share one read port: the updated axis or the reporting axis.
    assign w_sum_addr = (r_state == lrw_pkg::S_UPD) ? r_axis : r_ax_cnt;
    assign w_cs_sel   = r_cs[w_sum_addr];
    assign w_sq_sel   = r_sq[w_sum_addr];
    assign w_cs_mag   = w_cs_sel[CS_W-1] ? CS_W'(-w_cs_sel) : CS_W'(w_cs_sel);

    // Position update with saturation; square sum moves by +-2*old + 1.
    assign w_old      = $signed(w_mem_rdata);
    assign w_can      = r_move && (r_up ? (w_old != POS_MAX) : (w_old != POS_MIN));
    assign w_new      = r_up ? w_old + POS_BITS'(1) : w_old - POS_BITS'(1);
    assign w_old_x    = (SQ_W+1)'(w_old);
    assign w_sq_delta = r_up ? (w_old_x <<< 1) + (SQ_W+1)'(1)
                             : (SQ_W+1)'(1) - (w_old_x <<< 1);
    assign n_cs       = r_up ? w_cs_sel + CS_W'(1) : w_cs_sel - CS_W'(1);
    assign n_sq       = SQ_W'($signed({1'b0, w_sq_sel}) + w_sq_delta);
    assign w_step_end = ((r_widx + WK_W'(1)) == r_walkers);

    always_comb begin
        unique case (r_state)
            lrw_pkg::S_CLEAR: begin
                w_mem_we    = 1'b1;
                w_mem_addr  = r_clr_addr;
                w_mem_wdata = '0;
            end
            lrw_pkg::S_UPD: begin
                w_mem_we    = w_can;
                w_mem_addr  = r_addr;
                w_mem_wdata = w_new;
            end
            default: begin
                w_mem_we    = 1'b0;
                w_mem_addr  = w_draw_addr;
                w_mem_wdata = '0;
            end
        endcase
    end

    lrw_ram #(
        .WIDTH (POS_BITS),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_addr  (w_mem_addr),
        .i_wdata (w_mem_wdata),
        .o_rdata (w_mem_rdata)
    );

    // Divider: mean pass on |coord_sum|*256, then mean-square pass on square_sum*256.
    assign w_div_start    = r_go && (r_state == lrw_pkg::S_DMEAN ||
                                     r_state == lrw_pkg::S_DMSQ);
    assign w_div_dividend = (r_state == lrw_pkg::S_DMEAN)
                            ? DV_W'({w_cs_mag, 8'b0})
                            : {w_sq_sel, 8'b0};

    lrw_div #(
        .DW (DV_W),
        .VW (WK_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (r_walkers),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    assign w_quo_mean = r_neg ? -$signed(w_div_quo[MN_W-1:0]) : $signed(w_div_quo[MN_W-1:0]);
    assign w_quo_msq  = w_div_quo[MQ_W-1:0];
    assign w_ax_last  = ((DIM_W'(r_ax_cnt) + DIM_W'(1)) == r_dims);
    assign n_msd      = r_msd + MD_W'(r_msq);
    assign w_mean_x   = MNX_W'(r_mean);
    assign w_msq_x    = MQX_W'(r_msq);
    assign w_msd_x    = MDX_W'(n_msd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lrw_pkg::S_CLEAR;
            r_dims      <= DIM_W'(DIMS_RST);
            r_walkers   <= WK_W'(1);
            r_widx      <= '0;
            r_step      <= '0;
            r_clr_addr  <= '0;
            r_ax_cnt    <= '0;
            r_go        <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_DIMS; i++) begin
                r_cs[i] <= '0;
                r_sq[i] <= '0;
            end
        end else if (w_cfg_wr) begin
            if (i_cfg_index == lrw_pkg::REG_DIMENSIONS) begin
                r_dims <= w_cfg_dims;
            end else begin
                r_walkers <= w_cfg_walk;
            end
            r_state     <= lrw_pkg::S_CLEAR;
            r_widx      <= '0;
            r_step      <= '0;
            r_clr_addr  <= '0;
            r_ax_cnt    <= '0;
            r_go        <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_DIMS; i++) begin
                r_cs[i] <= '0;
                r_sq[i] <= '0;
            end
        end else begin
            if (r_out_valid && i_out_ready && r_state != lrw_pkg::S_EMIT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                lrw_pkg::S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(DEPTH - 1)) begin
                        r_state <= lrw_pkg::S_IDLE;
                    end
                end
                lrw_pkg::S_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= lrw_pkg::S_UPD;
                    end
                end
                lrw_pkg::S_UPD: begin
                    if (w_can) begin
                        r_cs[r_axis] <= n_cs;
                        r_sq[r_axis] <= n_sq;
                    end
                    if (w_step_end) begin
                        r_widx   <= '0;
                        r_step   <= r_step + 1'b1;
                        r_ax_cnt <= '0;
                        r_msd    <= '0;
                        r_go     <= 1'b1;
                        r_state  <= lrw_pkg::S_DMEAN;
                    end else begin
                        r_widx  <= r_widx + WK_W'(1);
                        r_state <= lrw_pkg::S_IDLE;
                    end
                end
                lrw_pkg::S_DMEAN: begin
                    if (r_go) begin
                        r_go  <= 1'b0;
                        r_neg <= w_cs_sel[CS_W-1];
                    end else if (w_div_done) begin
                        r_mean  <= w_quo_mean;
                        r_go    <= 1'b1;
                        r_state <= lrw_pkg::S_DMSQ;
                    end
                end
                lrw_pkg::S_DMSQ: begin
                    if (r_go) begin
                        r_go <= 1'b0;
                    end else if (w_div_done) begin
                        r_msq   <= w_quo_msq;
                        r_state <= lrw_pkg::S_EMIT;
                    end
                end
                lrw_pkg::S_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_msd       <= n_msd;
                        if (w_ax_last) begin
                            r_state <= lrw_pkg::S_IDLE;
                        end else begin
                            r_ax_cnt <= r_ax_cnt + AX_W'(1);
                            r_go     <= 1'b1;
                            r_state  <= lrw_pkg::S_DMEAN;
                        end
                    end
                end
                default: begin
                    r_state <= lrw_pkg::S_CLEAR;
                end
            endcase
        end
    end

    // Beat capture and output payload registers.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_addr <= w_draw_addr;
            r_axis <= AX_W'(w_draw_axis);
            r_up   <= i_direction_draw[0];
            r_move <= w_draw_ok;
        end
        if (r_state == lrw_pkg::S_EMIT && w_out_free) begin
            r_o_step <= r_step;
            r_o_axis <= lrw_pkg::AXIS_W'(r_ax_cnt);
            r_o_mean <= w_mean_x[lrw_pkg::MEAN_W-1:0];
            r_o_msq  <= w_msq_x[lrw_pkg::MSQ_W-1:0];
            r_o_msd  <= w_ax_last ? w_msd_x[lrw_pkg::MSD_W-1:0] : '0;
            r_o_last <= w_ax_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_step_number   = r_o_step;
    assign o_axis_index    = r_o_axis;
    assign o_mean_position = r_o_mean;
    assign o_mean_square   = r_o_msq;
    assign o_msd_total     = r_o_msd;
    assign o_last          = r_o_last;

endmodule

// ----- hdl/lrw_ram.sv -----
// Lattice random walk: generic single-port synchronous RAM.
// One address per cycle, registered read data. No dependencies.
module lrw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/lrw_div.sv -----
// Lattice random walk: restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
module lrw_div #(
    parameter int DW = 49,
    parameter int VW = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);

    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_den;
    logic [DW-1:0] r_quo;

    logic [VW:0]   w_trial;
    logic [VW:0]   w_diff;
    logic          w_ge;

    assign w_trial = {r_rem, r_quo[DW-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[VW-1:0] : w_trial[VW-1:0];
            r_quo <= {r_quo[DW-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
